[rtl/x86_status_flags_unit_defines.svh]
// assertion macros for the x86 status flags unit
// used by files that carry concurrent assertions; no other dependencies
`ifndef X86_STATUS_FLAGS_UNIT_DEFINES_SVH
`define X86_STATUS_FLAGS_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define XSF_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("x86 status flags unit: assertion failed");

// antecedent implies consequent in the next cycle
`define XSF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("x86 status flags unit: assertion failed");

`else

`define XSF_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define XSF_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

[rtl/xsf_pkg.sv]
// shared types, operation codes and width helpers of the status flags unit
// no dependencies
`timescale 1ns / 1ps

package xsf_pkg;

   localparam logic [3:0] OP_ADD   = 4'd0;
   localparam logic [3:0] OP_SUB   = 4'd1;
   localparam logic [3:0] OP_LOGIC = 4'd2;
   localparam logic [3:0] OP_INC   = 4'd3;
   localparam logic [3:0] OP_DEC   = 4'd4;
   localparam logic [3:0] OP_SHL   = 4'd5;
   localparam logic [3:0] OP_SHR   = 4'd6;
   localparam logic [3:0] OP_SAR   = 4'd7;
   localparam logic [3:0] OP_ROL   = 4'd8;
   localparam logic [3:0] OP_ROR   = 4'd9;
   localparam logic [3:0] OP_NEG   = 4'd10;
   localparam logic [3:0] OP_TEST  = 4'd11;

   localparam logic [1:0] WIDTH_8  = 2'd0;
   localparam logic [1:0] WIDTH_16 = 2'd1;
   localparam logic [1:0] WIDTH_32 = 2'd2;
   localparam logic [1:0] WIDTH_64 = 2'd3;

   typedef struct packed {
      logic [3:0]  req_type;
      logic [1:0]  width_code;
      logic [63:0] operand_a;
      logic [63:0] operand_b;
      logic        carry_bit;
      logic [7:0]  shift_count;
   } req_item_type;

   // bit 0 is cf, bit 5 is of
   typedef struct packed {
      logic overflow_flag;
      logic aux_flag;
      logic parity_flag;
      logic sign_flag;
      logic zero_flag;
      logic carry_flag;
   } rsp_item_type;

   function automatic logic [63:0] width_mask(input logic [1:0] wc);
      logic [63:0] m;
      unique case (wc)
         WIDTH_8:  m = 64'h0000_0000_0000_00FF;
         WIDTH_16: m = 64'h0000_0000_0000_FFFF;
         WIDTH_32: m = 64'h0000_0000_FFFF_FFFF;
         default:  m = 64'hFFFF_FFFF_FFFF_FFFF;
      endcase
      return m;
   endfunction

   function automatic logic [63:0] width_msb(input logic [1:0] wc);
      logic [63:0] m;
      unique case (wc)
         WIDTH_8:  m = 64'h0000_0000_0000_0080;
         WIDTH_16: m = 64'h0000_0000_0000_8000;
         WIDTH_32: m = 64'h0000_0000_8000_0000;
         default:  m = 64'h8000_0000_0000_0000;
      endcase
      return m;
   endfunction

   function automatic logic top_bit(input logic [63:0] v, input logic [1:0] wc);
      logic b;
      unique case (wc)
         WIDTH_8:  b = v[7];
         WIDTH_16: b = v[15];
         WIDTH_32: b = v[31];
         default:  b = v[63];
      endcase
      return b;
   endfunction

   function automatic logic second_bit(input logic [63:0] v, input logic [1:0] wc);
      logic b;
      unique case (wc)
         WIDTH_8:  b = v[6];
         WIDTH_16: b = v[14];
         WIDTH_32: b = v[30];
         default:  b = v[62];
      endcase
      return b;
   endfunction

   function automatic logic even_parity(input logic [63:0] v);
      return ~(^v[7:0]);
   endfunction

endpackage

[rtl/xsf_stream_if.sv]
// valid/ready channel carrying one item of a given payload type
// depends on nothing; payload types come from xsf_pkg at the instance
`timescale 1ns / 1ps

interface xsf_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[rtl/xsf_flag_calc.sv]
// next-flag logic: one operation against the current flags
// depends on xsf_pkg
`timescale 1ns / 1ps

module xsf_flag_calc (
   input  xsf_pkg::req_item_type item,
   input  xsf_pkg::rsp_item_type flags_cur,
   output xsf_pkg::rsp_item_type flags_nxt
);
   import xsf_pkg::*;

   logic [1:0]  wc;
   logic [63:0] mask;
   logic [63:0] msb;
   logic [63:0] a;
   logic [63:0] b;
   logic        sign;
   logic [6:0]  wbits;
   logic [5:0]  scnt;
   logic [5:0]  rcnt;
   logic [5:0]  scnt_m1;
   logic [6:0]  shl_diff;
   logic [6:0]  rot_back;

   logic        unit_op;
   logic [63:0] arith_b;
   logic        arith_c;
   logic [63:0] add_r;
   logic [63:0] add_co;
   logic [63:0] sub_r;
   logic [63:0] sub_bo;
   logic [63:0] logic_r;
   logic [63:0] shl_r;
   logic        shl_cf;
   logic [63:0] shr_r;
   logic        shr_cf;
   logic [63:0] a_ext;
   logic [63:0] sar_r;
   logic        sar_cf;
   logic [63:0] rol_r;
   logic [63:0] ror_r;
   logic [63:0] neg_r;

   assign wc    = item.width_code;
   assign mask  = width_mask(wc);
   assign msb   = width_msb(wc);
   assign a     = item.operand_a & mask;
   assign b     = item.operand_b & mask;
   assign sign  = top_bit(a, wc);
   assign wbits = 7'd8 << wc;

   assign scnt     = (wc == WIDTH_64) ? item.shift_count[5:0] : {1'b0, item.shift_count[4:0]};
   assign rcnt     = item.shift_count[5:0] & (wbits[5:0] - 6'd1);
   assign scnt_m1  = scnt - 6'd1;
   assign shl_diff = wbits - {1'b0, scnt};
   assign rot_back = wbits - {1'b0, rcnt};

   // add, sub, inc, dec
   assign unit_op = (item.req_type == OP_INC) || (item.req_type == OP_DEC);
   assign arith_b = unit_op ? 64'd1 : b;
   assign arith_c = unit_op ? 1'b0 : item.carry_bit;
   assign add_r   = (a + arith_b + {63'd0, arith_c}) & mask;
   assign add_co  = (a & arith_b) | ((a ^ arith_b) & ~add_r);
   assign sub_r   = (a - arith_b - {63'd0, arith_c}) & mask;
   assign sub_bo  = (~a & arith_b) | (~(a ^ arith_b) & sub_r);

   assign logic_r = (item.req_type == OP_TEST) ? (a & b) : a;

   // shifts
   assign shl_r  = (a << scnt) & mask;
   assign shl_cf = ({1'b0, scnt} <= wbits) ? a[shl_diff[5:0]] : 1'b0;
   assign shr_r  = a >> scnt;
   assign shr_cf = a[scnt_m1];
   assign a_ext  = a | (sign ? ~mask : 64'd0);
   assign sar_r  = 64'($signed(a_ext) >>> scnt) & mask;
   assign sar_cf = a_ext[scnt_m1];

   // rotates
   assign rol_r = ((a << rcnt) | (a >> rot_back)) & mask;
   assign ror_r = ((a >> rcnt) | (a << rot_back)) & mask;

   assign neg_r = (64'd0 - a) & mask;

   always_comb begin
      flags_nxt = flags_cur;
      unique case (item.req_type) inside
         OP_ADD, OP_INC: begin
            flags_nxt.carry_flag    = (item.req_type == OP_INC) ? flags_cur.carry_flag
                                                                : top_bit(add_co, wc);
            flags_nxt.zero_flag     = (add_r == 64'd0);
            flags_nxt.sign_flag     = top_bit(add_r, wc);
            flags_nxt.parity_flag   = even_parity(add_r);
            flags_nxt.aux_flag      = a[4] ^ arith_b[4] ^ add_r[4];
            flags_nxt.overflow_flag = top_bit((a ^ add_r) & (arith_b ^ add_r), wc);
         end
         OP_SUB, OP_DEC: begin
            flags_nxt.carry_flag    = (item.req_type == OP_DEC) ? flags_cur.carry_flag
                                                                : top_bit(sub_bo, wc);
            flags_nxt.zero_flag     = (sub_r == 64'd0);
            flags_nxt.sign_flag     = top_bit(sub_r, wc);
            flags_nxt.parity_flag   = even_parity(sub_r);
            flags_nxt.aux_flag      = a[4] ^ arith_b[4] ^ sub_r[4];
            flags_nxt.overflow_flag = top_bit((a ^ arith_b) & (a ^ sub_r), wc);
         end
         OP_LOGIC, OP_TEST: begin
            flags_nxt.carry_flag    = 1'b0;
            flags_nxt.zero_flag     = (logic_r == 64'd0);
            flags_nxt.sign_flag     = top_bit(logic_r, wc);
            flags_nxt.parity_flag   = even_parity(logic_r);
            flags_nxt.aux_flag      = 1'b0;
            flags_nxt.overflow_flag = 1'b0;
         end
         OP_SHL: begin
            if (scnt != 6'd0) begin
               flags_nxt.carry_flag  = shl_cf;
               flags_nxt.zero_flag   = (shl_r == 64'd0);
               flags_nxt.sign_flag   = top_bit(shl_r, wc);
               flags_nxt.parity_flag = even_parity(shl_r);
               if (scnt == 6'd1) begin
                  flags_nxt.overflow_flag = top_bit(shl_r, wc) ^ shl_cf;
               end
            end
         end
         OP_SHR: begin
            if (scnt != 6'd0) begin
               flags_nxt.carry_flag  = shr_cf;
               flags_nxt.zero_flag   = (shr_r == 64'd0);
               flags_nxt.sign_flag   = top_bit(shr_r, wc);
               flags_nxt.parity_flag = even_parity(shr_r);
               if (scnt == 6'd1) begin
                  flags_nxt.overflow_flag = sign;
               end
            end
         end
         OP_SAR: begin
            if (scnt != 6'd0) begin
               flags_nxt.carry_flag  = sar_cf;
               flags_nxt.zero_flag   = (sar_r == 64'd0);
               flags_nxt.sign_flag   = top_bit(sar_r, wc);
               flags_nxt.parity_flag = even_parity(sar_r);
               if (scnt == 6'd1) begin
                  flags_nxt.overflow_flag = 1'b0;
               end
            end
         end
         OP_ROL: begin
            if (rcnt != 6'd0) begin
               flags_nxt.carry_flag    = rol_r[0];
               flags_nxt.overflow_flag = top_bit(rol_r, wc) ^ rol_r[0];
            end
         end
         OP_ROR: begin
            if (rcnt != 6'd0) begin
               flags_nxt.carry_flag    = top_bit(ror_r, wc);
               flags_nxt.overflow_flag = top_bit(ror_r, wc) ^ second_bit(ror_r, wc);
            end
         end
         OP_NEG: begin
            flags_nxt.carry_flag    = (a != 64'd0);
            flags_nxt.zero_flag     = (neg_r == 64'd0);
            flags_nxt.sign_flag     = top_bit(neg_r, wc);
            flags_nxt.parity_flag   = even_parity(neg_r);
            flags_nxt.aux_flag      = a[4] ^ neg_r[4];
            flags_nxt.overflow_flag = (a == msb);
         end
         default: begin
            flags_nxt = flags_cur;
         end
      endcase
   end

endmodule

[rtl/x86_status_flags_unit.sv]
// x86 status flags unit: input register, flag logic, flag/result register
// depends on xsf_pkg, xsf_stream_if, xsf_flag_calc and the assertion header
//
//   channel   dir   handshake      payload
//   req_chan  in    valid/ready    req_type, width_code, operand_a/b, carry_bit, shift_count
//   rsp_chan  out   valid/ready    carry, zero, sign, parity, aux, overflow flags
//
// one item per cycle unless rsp_chan stalls; item path: input register, then flag register
// the limit is the six-bit flag register, which each item reads and writes
// synchronous reset clears both valid bits and sets all flags to zero
// a stalled result holds the flags; the input register still takes one more item
`timescale 1ns / 1ps
`include "x86_status_flags_unit_defines.svh"

module x86_status_flags_unit (
   input logic           clock,
   input logic           reset,
   xsf_stream_if.sink    req_chan,
   xsf_stream_if.source  rsp_chan
);
   import xsf_pkg::*;

   logic         s1_valid_ff;
   logic         s1_valid_in;
   req_item_type s1_item_ff;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_item_type flag_ff;
   rsp_item_type flag_in;
   rsp_item_type calc_flags;
   logic         req_take;
   logic         advance;

   assign advance  = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !s1_valid_ff || advance;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = flag_ff;

   xsf_flag_calc u_calc (
      .item      (s1_item_ff),
      .flags_cur (flag_ff),
      .flags_nxt (calc_flags)
   );

   assign s1_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
   assign flag_in      = advance ? calc_flags : flag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         flag_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         flag_ff      <= flag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff <= req_chan.data;
      end
   end

   `XSF_ASSERT_NEXT(a_advance_gives_result, clock, reset, advance, rsp_valid_ff)
   `XSF_ASSERT_NEXT(a_flags_hold_when_idle, clock, reset, !advance, $stable(flag_ff))
   `XSF_ASSERT_SAME(a_empty_stage_ready, clock, reset, !s1_valid_ff, req_chan.ready)
   `XSF_ASSERT_NEXT(a_take_fills_stage, clock, reset, req_take, s1_valid_ff)

endmodule

[sim/x86_status_flags_unit_test.sv]
// self-checking bench for the x86 status flags unit: a directed table, then random items
// under idle, stall and hold-off mixes, each result checked against a flag predictor or pinned flags
// depends on xsf_pkg, xsf_stream_if and x86_status_flags_unit from the rtl folder
`timescale 1ns / 1ps

module x86_status_flags_unit_test;
   import xsf_pkg::*;

   localparam logic [3:0] OP_UNUSED_LO = 4'd12;
   localparam logic [3:0] OP_UNUSED_HI = 4'd15;
   localparam int RESET_CYCLES   = 11;
   localparam int HOLD_CYCLES    = 48;
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct {
      req_item_type item;
      logic         pinned;
      rsp_item_type flags;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   xsf_stream_if #(.payload_type(req_item_type)) req_chan ();
   xsf_stream_if #(.payload_type(rsp_item_type)) rsp_chan ();

   x86_status_flags_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   stim_row_type directed_rows[$];
   stim_row_type rows_in_flight_q[$];
   rsp_item_type flags_due_q[$];
   rsp_item_type flags_now = '0;
   string        flag_names [6] = '{"carry", "zero", "sign", "parity", "aux", "overflow"};
   int           send_idle_pct = 0;
   int           rcv_stall_pct = 0;
   int           rsp_hold_cycles = 0;
   int           n_items = 0;
   int           n_checked = 0;
   int           n_errors = 0;
   int           quiet_cycles = 0;

   // flags after one item, starting from the current flags
   function automatic rsp_item_type flags_after(input rsp_item_type cur, input req_item_type it);
      rsp_item_type f;
      int unsigned  w, scnt, rcnt;
      logic [63:0]  mask, msb, a, b, c, r, t;
      logic         sign, cf, zsp;
      f = cur;
      zsp = 1'b0;
      r = '0;
      w = 8 << it.width_code;
      mask = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
      msb = 64'd1 << (w - 1);
      a = it.operand_a & mask;
      b = it.operand_b & mask;
      c = {63'd0, it.carry_bit};
      scnt = 32'(it.shift_count) & ((w == 64) ? 32'h3F : 32'h1F);
      rcnt = it.shift_count & (w - 1);
      sign = |(a & msb);
      case (it.req_type)
         OP_ADD, OP_INC: begin
            if (it.req_type == OP_INC) begin
               b = 64'd1;
               c = 64'd0;
            end
            r = (a + b + c) & mask;
            t = (a & b) | ((a ^ b) & ~r);
            if (it.req_type == OP_ADD) f.carry_flag = |(t & msb);
            t = a ^ b ^ r;
            f.aux_flag = t[4];
            f.overflow_flag = |((a ^ r) & (b ^ r) & msb);
            zsp = 1'b1;
         end
         OP_SUB, OP_DEC: begin
            if (it.req_type == OP_DEC) begin
               b = 64'd1;
               c = 64'd0;
            end
            r = (a - b - c) & mask;
            t = (~a & b) | (~(a ^ b) & r);
            if (it.req_type == OP_SUB) f.carry_flag = |(t & msb);
            t = a ^ b ^ r;
            f.aux_flag = t[4];
            f.overflow_flag = |((a ^ b) & (a ^ r) & msb);
            zsp = 1'b1;
         end
         OP_LOGIC, OP_TEST: begin
            r = (it.req_type == OP_TEST) ? (a & b) : a;
            f.carry_flag = 1'b0;
            f.aux_flag = 1'b0;
            f.overflow_flag = 1'b0;
            zsp = 1'b1;
         end
         OP_SHL: begin
            if (scnt != 0) begin
               r = (scnt >= w) ? 64'd0 : ((a << scnt) & mask);
               cf = (scnt <= w) ? a[w - scnt] : 1'b0;
               f.carry_flag = cf;
               if (scnt == 1) f.overflow_flag = (|(r & msb)) ^ cf;
               zsp = 1'b1;
            end
         end
         OP_SHR: begin
            if (scnt != 0) begin
               r = (scnt >= w) ? 64'd0 : (a >> scnt);
               f.carry_flag = (scnt - 1 < w) ? a[scnt - 1] : 1'b0;
               if (scnt == 1) f.overflow_flag = sign;
               zsp = 1'b1;
            end
         end
         OP_SAR: begin
            if (scnt != 0) begin
               if (scnt >= w) r = sign ? mask : 64'd0;
               else r = (a >> scnt) | (sign ? (mask & ~(mask >> scnt)) : 64'd0);
               f.carry_flag = (scnt - 1 < w) ? a[scnt - 1] : sign;
               if (scnt == 1) f.overflow_flag = 1'b0;
               zsp = 1'b1;
            end
         end
         OP_ROL: begin
            if (rcnt != 0) begin
               r = ((a << rcnt) | (a >> (w - rcnt))) & mask;
               f.carry_flag = r[0];
               f.overflow_flag = (|(r & msb)) ^ r[0];
            end
         end
         OP_ROR: begin
            if (rcnt != 0) begin
               r = ((a >> rcnt) | (a << (w - rcnt))) & mask;
               cf = |(r & msb);
               f.carry_flag = cf;
               f.overflow_flag = cf ^ r[w - 2];
            end
         end
         OP_NEG: begin
            r = (64'd0 - a) & mask;
            f.carry_flag = (a != 64'd0);
            t = a ^ r;
            f.aux_flag = t[4];
            f.overflow_flag = (a == msb);
            zsp = 1'b1;
         end
         default: begin
         end
      endcase
      if (zsp) begin
         f.zero_flag = (r == 64'd0);
         f.sign_flag = |(r & msb);
         f.parity_flag = ~(^r[7:0]);
      end
      return f;
   endfunction

   function automatic stim_row_type dir_row(input logic [3:0] op, input logic [1:0] wc,
                                            input logic [63:0] a, input logic [63:0] b,
                                            input logic c, input logic [7:0] cnt,
                                            input logic pinned, input logic [5:0] flags);
      stim_row_type row;
      row.item.req_type = op;
      row.item.width_code = wc;
      row.item.operand_a = a;
      row.item.operand_b = b;
      row.item.carry_bit = c;
      row.item.shift_count = cnt;
      row.pinned = pinned;
      row.flags = flags;
      return row;
   endfunction

   function automatic logic [63:0] random_operand();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(7))
         0: v = '0;
         1: v = '1;
         2: v = 64'd1 << ((8 << $urandom_range(3)) - 1);
         3: v = 64'd1 << $urandom_range(63);
         4: v = ~(64'd1 << $urandom_range(63));
         5: v = v & 64'hFF;
         default: begin
         end
      endcase
      return v;
   endfunction

   function automatic stim_row_type random_row();
      stim_row_type row;
      int unsigned  w;
      if ($urandom_range(19) == 0)
         row.item.req_type = 4'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
      else row.item.req_type = 4'($urandom_range(OP_TEST, OP_ADD));
      row.item.width_code = 2'($urandom_range(3));
      row.item.operand_a = random_operand();
      row.item.operand_b = random_operand();
      row.item.carry_bit = 1'($urandom_range(1));
      w = 8 << row.item.width_code;
      case ($urandom_range(3))
         0: row.item.shift_count = 8'($urandom_range(255));
         1: row.item.shift_count = 8'($urandom_range(2));
         2: row.item.shift_count = 8'(w - 2 + $urandom_range(4));
         default: row.item.shift_count = 8'(($urandom_range(7) << 5) | $urandom_range(3));
      endcase
      row.pinned = 1'b0;
      row.flags = '0;
      return row;
   endfunction

   task automatic send_item(input stim_row_type row);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      rows_in_flight_q.push_back(row);
      req_chan.valid <= 1'b1;
      req_chan.data <= row.item;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic run_phase(input int count, input int idle_pct, input int stall_pct);
      send_idle_pct = idle_pct;
      rcv_stall_pct = stall_pct;
      repeat (count) send_item(random_row());
   endtask

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end
         rsp_chan.ready <= ($urandom_range(99) >= rcv_stall_pct);
      end
   end

   always @(posedge clock) begin : flag_check
      stim_row_type row;
      rsp_item_type want;
      rsp_item_type got;
      int           i;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            row = rows_in_flight_q.pop_front();
            flags_now = flags_after(flags_now, req_chan.data);
            flags_due_q.push_back(row.pinned ? row.flags : flags_now);
            n_items++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = rsp_chan.data;
            if (flags_due_q.size() == 0) begin
               $display("%0t: unexpected flags item: expected none actual %b", $time, got);
               n_errors++;
            end else begin
               want = flags_due_q.pop_front();
               n_checked++;
               for (i = 0; i < 6; i++) begin
                  if (want[i] !== got[i]) begin
                     $display("%0t: %s flag mismatch: expected %b actual %b",
                              $time, flag_names[i], want[i], got[i]);
                     n_errors++;
                  end
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
         $display("FAIL x86_status_flags_unit");
         $finish;
      end
   end

   initial begin
      req_chan.valid <= 1'b0;
      req_chan.data <= '0;

      // flags in order: of af pf sf zf cf
      directed_rows.push_back(dir_row(OP_SHL, WIDTH_8, 64'hFF, 64'h0, 1'b0, 8'h20, 1'b1, 6'b000000));
      directed_rows.push_back(dir_row(OP_LOGIC, WIDTH_8, 64'hFFFF_FFFF_FFFF_FF00, 64'h0, 1'b1,
                                      8'h0, 1'b1, 6'b001010));
      directed_rows.push_back(dir_row(OP_LOGIC, WIDTH_8, 64'h80, 64'h0, 1'b0, 8'h0,
                                      1'b1, 6'b000100));
      directed_rows.push_back(dir_row(OP_NEG, WIDTH_64, 64'h8000_0000_0000_0000, 64'h0, 1'b0,
                                      8'h0, 1'b1, 6'b101101));
      directed_rows.push_back(dir_row(OP_UNUSED_LO, WIDTH_32, '1, '1, 1'b1, 8'hFF,
                                      1'b1, 6'b101101));
      directed_rows.push_back(dir_row(OP_UNUSED_HI, WIDTH_8, 64'h0, 64'h0, 1'b0, 8'h1,
                                      1'b1, 6'b101101));
      directed_rows.push_back(dir_row(OP_ADD, WIDTH_8, 64'hFF, 64'h0, 1'b1, 8'h0, 1'b0, '0));
      directed_rows.push_back(dir_row(OP_ADD, WIDTH_64, '1, '1, 1'b1, 8'h0, 1'b0, '0));
      directed_rows.push_back(dir_row(OP_SUB, WIDTH_16, 64'h0, 64'h1, 1'b1, 8'h0, 1'b0, '0));
      directed_rows.push_back(dir_row(OP_SUB, WIDTH_32, 64'h8000_0000, 64'h1, 1'b0, 8'h0,
                                      1'b0, '0));
      directed_rows.push_back(dir_row(OP_INC, WIDTH_8, 64'h7F, 64'h0, 1'b0, 8'h0, 1'b0, '0));
      directed_rows.push_back(dir_row(OP_DEC, WIDTH_16, 64'h8000, 64'h0, 1'b0, 8'h0, 1'b0, '0));
      directed_rows.push_back(dir_row(OP_SHL, WIDTH_8, 64'h81, 64'h0, 1'b0, 8'h1, 1'b0, '0));
      directed_rows.push_back(dir_row(OP_SHL, WIDTH_8, 64'h01, 64'h0, 1'b0, 8'h8, 1'b0, '0));
      directed_rows.push_back(dir_row(OP_SHL, WIDTH_16, 64'hFFFF, 64'h0, 1'b0, 8'h11, 1'b0, '0));
      directed_rows.push_back(dir_row(OP_SHR, WIDTH_64, 64'h8000_0000_0000_0001, 64'h0, 1'b0,
                                      8'h1, 1'b0, '0));
      directed_rows.push_back(dir_row(OP_SHR, WIDTH_8, 64'h80, 64'h0, 1'b0, 8'h1F, 1'b0, '0));
      directed_rows.push_back(dir_row(OP_SAR, WIDTH_8, 64'h80, 64'h0, 1'b0, 8'h9, 1'b0, '0));
      directed_rows.push_back(dir_row(OP_SAR, WIDTH_32, 64'hFFFF_FFFF, 64'h0, 1'b0, 8'h1,
                                      1'b0, '0));
      directed_rows.push_back(dir_row(OP_ROL, WIDTH_8, 64'h80, 64'h0, 1'b0, 8'h1, 1'b0, '0));
      directed_rows.push_back(dir_row(OP_ROL, WIDTH_8, 64'h55, 64'h0, 1'b0, 8'h8, 1'b0, '0));
      directed_rows.push_back(dir_row(OP_ROR, WIDTH_64, 64'h1, 64'h0, 1'b0, 8'hFF, 1'b0, '0));
      directed_rows.push_back(dir_row(OP_ROR, WIDTH_16, 64'h1, 64'h0, 1'b0, 8'h1, 1'b0, '0));
      directed_rows.push_back(dir_row(OP_NEG, WIDTH_32, 64'h0, 64'h0, 1'b0, 8'h0, 1'b0, '0));
      directed_rows.push_back(dir_row(OP_TEST, WIDTH_64, '1, 64'h8000_0000_0000_00FF, 1'b0,
                                      8'h0, 1'b0, '0));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k]) send_item(directed_rows[k]);
      run_phase(450, 0, 0);
      run_phase(400, 80, 0);
      run_phase(400, 0, 80);
      run_phase(350, 26, 26);
      // receiver holds off while the sender keeps offering
      rsp_hold_cycles = HOLD_CYCLES;
      run_phase(60, 0, 0);
      req_chan.valid <= 1'b0;

      @(posedge clock);
      while (flags_due_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (flags_due_q.size() != 0) n_errors++;

      $display("covered %0d items (%0d directed) over all operations, unused codes and 4 widths",
               n_items, directed_rows.size());
      $display("checked %0d flag results under idle, stall and a %0d-cycle hold-off; %0d errors",
               n_checked, HOLD_CYCLES, n_errors);
      if (n_errors == 0)
         $display("PASS x86_status_flags_unit");
      else
         $display("FAIL x86_status_flags_unit");
      $finish;
   end

endmodule
